[hdl/qoi_enc_pkg.sv]
// ----------------------------------------------------------------------------
// qoi_enc_pkg
// Shared constants, types and the index hash for the QOI pixel encoder.
// ----------------------------------------------------------------------------
package qoi_enc_pkg;

  // seen-pixel table geometry
  localparam int TableDepth = 64;
  localparam int HashW      = $clog2(TableDepth);

  // run op limit
  localparam int RunLimit   = 62;

  // bytes one pixel can leave ahead of the end marker: run byte plus rgba op
  localparam int RecBytes   = 6;
  localparam int TailBytes  = 8;

  // op codes and stream constants
  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hC0;
  localparam logic [7:0] OP_RGB   = 8'hFE;
  localparam logic [7:0] OP_RGBA  = 8'hFF;
  localparam logic [7:0] END_FILL = 8'h00;
  localparam logic [7:0] END_MARK = 8'h01;

  // register indexes on the control port
  localparam logic REG_SWAP  = 1'b0;
  localparam logic REG_ALPHA = 1'b1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  localparam pixel_t RESET_PIXEL = '{r: 8'h00, g: 8'h00, b: 8'h00, a: 8'hFF};

  // bytes of one pixel handed to the serializer
  typedef struct packed {
    logic [RecBytes-1:0][7:0] data;
    logic [2:0]               count;
    logic                     tail;
  } byte_rec_t;

  // (3r + 5g + 7b + 11a) mod 64, only low bits matter
  function automatic logic [HashW-1:0] qoi_hash(input pixel_t p);
    logic [HashW-1:0] r6, g6, b6, a6;
    r6 = p.r[HashW-1:0];
    g6 = p.g[HashW-1:0];
    b6 = p.b[HashW-1:0];
    a6 = p.a[HashW-1:0];
    return HashW'(r6 * HashW'(3)) + HashW'(g6 * HashW'(5)) +
           HashW'(b6 * HashW'(7)) + HashW'(a6 * HashW'(11));
  endfunction

endpackage

[hdl/qoi_enc_ser.sv]
// ----------------------------------------------------------------------------
// qoi_enc_ser
// Byte serializer: holds one pixel's bytes and sends one word per cycle while
// out_stall is low, appending the eight-byte end marker after the last pixel.
// ----------------------------------------------------------------------------
module qoi_enc_ser
  import qoi_enc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load_valid,
  input  byte_rec_t rec,
  output logic      load_ready,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [7:0] out_byte,
  output logic      last_byte
);

  logic      busy;
  logic [3:0] idx;
  byte_rec_t rec_q;
  logic [3:0] len;
  logic      at_end;
  logic      done;
  logic [7:0] rec_byte;

  // total words of the held record
  assign len    = {1'b0, rec_q.count} + (rec_q.tail ? 4'(TailBytes) : 4'd0);
  assign at_end = (idx == len - 4'd1);
  assign done   = busy && !out_stall && at_end;

  assign load_ready = !busy || done;

  // control: busy flag and word index
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load_valid && load_ready) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy && !out_stall) begin
      idx <= idx + 4'd1;
    end
  end

  // held record
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      rec_q <= rec;
    end
  end

  // pick the pixel byte at the current index
  always_comb begin
    rec_byte = '0;
    for (int k = 0; k < RecBytes; k++) begin
      if (idx == 4'(k)) begin
        rec_byte = rec_q.data[k];
      end
    end
  end

  // output word
  always_comb begin
    if (idx < {1'b0, rec_q.count}) begin
      out_byte = rec_byte;
    end else if (at_end) begin
      out_byte = END_MARK;
    end else begin
      out_byte = END_FILL;
    end
  end

  assign out_valid = busy;
  assign last_byte = at_end;

endmodule

[hdl/qoi_pixel_encoder_unit.sv]
// ----------------------------------------------------------------------------
// qoi_pixel_encoder_unit
// QOI image body encoder: one pixel in, the QOI op bytes out.
// ----------------------------------------------------------------------------
// A pixel's seen-table entry is read from a 64-entry synchronous memory at
// the edge that takes the pixel, and the pixel is coded in the next cycle,
// where the entry is written back unless the pixel repeats the previous one
// (a forward covers the following pixel hitting the same entry). Coded bytes
// go to a serializer that sends one word per cycle while out_stall is low, so
// the sustained rate is one pixel per cycle while pixels make at most one
// byte; otherwise a pixel is held while its bytes are sent (up to 14 for the
// last pixel, which adds the eight-byte end marker). The first byte of a
// pixel is offered once its bytes are loaded into the serializer.
// After the last pixel the previous pixel, run count and table return to
// their reset values. No header is produced.
// ----------------------------------------------------------------------------
module qoi_pixel_encoder_unit
  import qoi_enc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // control port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  first_color,
  input  logic [7:0]  green,
  input  logic [7:0]  third_color,
  input  logic [7:0]  alpha,
  input  logic        last_pixel,
  // byte channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_byte
);

  logic swap_red_blue;
  logic alpha_present;

  pixel_t           in_pix;
  logic [HashW-1:0] in_hash;
  logic             accept;

  logic             s1_valid;
  pixel_t           s1_pix;
  logic [HashW-1:0] s1_hash;
  logic             s1_last;
  logic             s1_alt_use;
  pixel_t           s1_alt_pix;
  logic             s1_adv;
  logic             s1_fire;

  logic [31:0]          seen_mem [TableDepth];
  logic [TableDepth-1:0] seen_valid;
  pixel_t               table_q;
  logic                 tv_q;
  logic                 tbl_we;

  pixel_t    prev;
  logic [5:0] run;
  logic [5:0] run_next;
  logic      eq;

  byte_rec_t rec;
  logic      need_ser;
  logic      ser_ready;

  // control registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_red_blue <= 1'b0;
      alpha_present <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_SWAP:  swap_red_blue <= pwdata[0];
        REG_ALPHA: alpha_present <= pwdata[0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SWAP:  prdata = {31'b0, swap_red_blue};
      REG_ALPHA: prdata = {31'b0, alpha_present};
      default:   prdata = '0;
    endcase
  end

  // input pixel in r g b a order
  always_comb begin
    in_pix.r = swap_red_blue ? third_color : first_color;
    in_pix.g = green;
    in_pix.b = swap_red_blue ? first_color : third_color;
    in_pix.a = alpha_present ? alpha : 8'hFF;
  end

  assign in_hash  = qoi_hash(in_pix);
  assign accept   = in_valid && !in_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign s1_fire  = s1_valid && s1_adv;
  assign eq       = (s1_pix == prev);
  assign tbl_we   = s1_fire && !eq;

  // coding stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // coding stage payload, with forward of the entry written at this edge
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix     <= in_pix;
      s1_hash    <= in_hash;
      s1_last    <= last_pixel;
      tv_q       <= seen_valid[in_hash];
      s1_alt_use <= s1_fire && (s1_last || (tbl_we && s1_hash == in_hash));
      s1_alt_pix <= s1_last ? '0 : s1_pix;
    end
  end

  // seen table memory
  always_ff @(posedge clk) begin
    if (accept) begin
      table_q <= seen_mem[in_hash];
    end
    if (tbl_we) begin
      seen_mem[s1_hash] <= s1_pix;
    end
  end

  // entry valid bits, cleared at reset and after the last pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_valid <= '0;
    end else if (s1_fire && s1_last) begin
      seen_valid <= '0;
    end else if (tbl_we) begin
      seen_valid[s1_hash] <= 1'b1;
    end
  end

  // previous pixel and run count
  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= RESET_PIXEL;
      run  <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        prev <= RESET_PIXEL;
        run  <= '0;
      end else begin
        prev <= s1_pix;
        run  <= run_next;
      end
    end
  end

  // op selection
  always_comb begin
    pixel_t          entry;
    logic [5:0]      run_inc;
    logic [7:0]      dr, dg, db;
    logic [7:0]      er, eg, eb, lg, lr, lb;
    logic [5:0][7:0] op;
    logic [2:0]      op_n;
    logic            has_run;
    logic [7:0]      run_byte;

    entry    = s1_alt_use ? s1_alt_pix : (tv_q ? table_q : '0);
    run_inc  = run + 6'd1;
    dr       = s1_pix.r - prev.r;
    dg       = s1_pix.g - prev.g;
    db       = s1_pix.b - prev.b;
    er       = dr + 8'd2;
    eg       = dg + 8'd2;
    eb       = db + 8'd2;
    lg       = dg + 8'd32;
    lr       = dr - dg + 8'd8;
    lb       = db - dg + 8'd8;
    op       = '0;
    op_n     = '0;
    has_run  = 1'b0;
    run_byte = OP_RUN | {2'b00, run};
    run_next = '0;

    if (eq) begin
      // repeat of the previous pixel
      if (run_inc >= 6'(RunLimit) || s1_last) begin
        has_run = 1'b1;
      end else begin
        run_next = run_inc;
      end
    end else begin
      // flush a pending run first
      has_run  = (run != 6'd0);
      run_byte = OP_RUN | {2'b00, run - 6'd1};
      if (entry == s1_pix) begin
        op[0] = OP_INDEX | {2'b00, s1_hash};
        op_n  = 3'd1;
      end else if (s1_pix.a == prev.a) begin
        if (er < 8'd4 && eg < 8'd4 && eb < 8'd4) begin
          op[0] = OP_DIFF | {2'b00, er[1:0], eg[1:0], eb[1:0]};
          op_n  = 3'd1;
        end else if (lg < 8'd64 && lr < 8'd16 && lb < 8'd16) begin
          op[0] = OP_LUMA | {2'b00, lg[5:0]};
          op[1] = {lr[3:0], lb[3:0]};
          op_n  = 3'd2;
        end else begin
          op[0] = OP_RGB;
          op[1] = s1_pix.r;
          op[2] = s1_pix.g;
          op[3] = s1_pix.b;
          op_n  = 3'd4;
        end
      end else begin
        op[0] = OP_RGBA;
        op[1] = s1_pix.r;
        op[2] = s1_pix.g;
        op[3] = s1_pix.b;
        op[4] = s1_pix.a;
        op_n  = 3'd5;
      end
    end

    // pack run byte ahead of the op bytes
    rec.data[0] = has_run ? run_byte : op[0];
    for (int k = 1; k < RecBytes; k++) begin
      rec.data[k] = has_run ? op[k-1] : op[k];
    end
    rec.count = op_n + {2'b00, has_run};
    rec.tail  = s1_last;
  end

  assign need_ser = (rec.count != 3'd0) || s1_last;
  assign s1_adv   = !need_ser || ser_ready;

  qoi_enc_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s1_valid && need_ser),
    .rec        (rec),
    .load_ready (ser_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .last_byte  (last_byte)
  );

endmodule
